>>> rtl/cascaded_attitude_pid_mixer_top_defines.svh
// Assertion macros for the cascaded attitude PID mixer.
`ifndef CASCADED_ATTITUDE_PID_MIXER_TOP_DEFINES_SVH
`define CASCADED_ATTITUDE_PID_MIXER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define CAPM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("capm assertion failed");
// Next-cycle implication.
`define CAPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("capm assertion failed");
`else
`define CAPM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CAPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/capm_pkg.sv
// Shared types, constants and saturation helpers for the attitude PID mixer.
`default_nettype none
package capm_pkg;

  localparam int INTEG_LIMIT    = 100;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int NUM_REGS       = 8;

  typedef enum logic [2:0] {
    REG_ANGLE_KP_TILT = 3'd0,
    REG_ANGLE_KI_TILT = 3'd1,
    REG_ANGLE_KD_TILT = 3'd2,
    REG_ANGLE_KP_YAW  = 3'd3,
    REG_RATE_KP_PITCH = 3'd4,
    REG_RATE_KP_ROLL  = 3'd5,
    REG_RATE_KD_PITCH = 3'd6,
    REG_RATE_KD_ROLL  = 3'd7
  } reg_idx_e;

  localparam logic [15:0] CFG_RESET [NUM_REGS] = '{
    16'd1024, 16'd768, 16'd256, 16'd768, 16'd115, 16'd102, 16'd461, 16'd307
  };

  // Sequencer steps, one-hot.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ERR  = 8'b0000_0010,
    S_AMUL = 8'b0000_0100,
    S_ASUM = 8'b0000_1000,
    S_RERR = 8'b0001_0000,
    S_RMUL = 8'b0010_0000,
    S_RSUM = 8'b0100_0000,
    S_MIX  = 8'b1000_0000
  } step_e;

  typedef struct packed {
    step_e step;
    logic  armed;
  } ctl_t;

  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
    logic [15:0] rkp;
    logic [15:0] rkd;
  } lane_gain_t;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) r = 16'sh7fff;
    else if (v < -32'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [16:0] sat17(input logic signed [47:0] v);
    logic signed [16:0] r;
    if (v > 48'sd65535) r = 17'sh0ffff;
    else if (v < -48'sd65536) r = 17'sh10000;
    else r = v[16:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/cascaded_attitude_pid_mixer_top.sv
// An accepted input runs through steps ERR, AMUL, ASUM, RERR, RMUL, RSUM and MIX,
// and out_valid_o is registered when MIX loads the output register. Input stalls
// until the 7-step sequencer, which shares one product stage per loop across its
// steps, is idle again; input is then taken while a result waits in the output register.
// Reset: gains return to their defaults, integrators and previous errors clear.
`default_nettype none
`include "cascaded_attitude_pid_mixer_top_defines.svh"
module cascaded_attitude_pid_mixer_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] set_pitch_i,
  input  wire logic signed [15:0] set_roll_i,
  input  wire logic signed [15:0] set_yaw_i,
  input  wire logic signed [15:0] meas_pitch_i,
  input  wire logic signed [15:0] meas_roll_i,
  input  wire logic signed [15:0] meas_yaw_i,
  input  wire logic signed [15:0] rate_x_i,
  input  wire logic signed [15:0] rate_y_i,
  input  wire logic signed [15:0] rate_z_i,
  input  wire logic [14:0]        throttle_i,
  input  wire logic               armed_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      motor_a_o,
  output logic signed [15:0]      motor_b_o,
  output logic signed [15:0]      motor_c_o,
  output logic signed [15:0]      motor_d_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);

  capm_pkg::step_e step_q, step_d;
  logic [15:0] cfg_q [capm_pkg::NUM_REGS];

  logic signed [15:0] set_pitch_q, set_roll_q, set_yaw_q;
  logic signed [15:0] meas_pitch_q, meas_roll_q, meas_yaw_q;
  logic signed [15:0] rate_x_q, rate_y_q, rate_z_q;
  logic [14:0]        throttle_q;
  logic               armed_q;

  logic               out_valid_q;
  logic signed [15:0] motor_a_q, motor_b_q, motor_c_q, motor_d_q;
  logic signed [15:0] mix_a, mix_b, mix_c, mix_d;
  logic signed [15:0] pitch_out, roll_out;

  logic in_accept, out_free, out_load;
  capm_pkg::ctl_t          ctl;
  capm_pkg::lane_gain_t    gain_pitch, gain_roll;

  assign in_stall_o  = (step_q != capm_pkg::S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (step_q == capm_pkg::S_MIX) && out_free;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    step_d = step_q;
    unique case (step_q)
      capm_pkg::S_IDLE: if (in_accept) step_d = capm_pkg::S_ERR;
      capm_pkg::S_ERR:  step_d = capm_pkg::S_AMUL;
      capm_pkg::S_AMUL: step_d = capm_pkg::S_ASUM;
      capm_pkg::S_ASUM: step_d = capm_pkg::S_RERR;
      capm_pkg::S_RERR: step_d = capm_pkg::S_RMUL;
      capm_pkg::S_RMUL: step_d = capm_pkg::S_RSUM;
      capm_pkg::S_RSUM: step_d = capm_pkg::S_MIX;
      capm_pkg::S_MIX:  if (out_free) step_d = capm_pkg::S_IDLE;
      default:          step_d = capm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= capm_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < capm_pkg::NUM_REGS; i++) begin
        cfg_q[i] <= capm_pkg::CFG_RESET[i];
      end
    end else begin
      step_q <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        cfg_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  // Hold the input transaction for the whole sequence.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      set_pitch_q  <= set_pitch_i;
      set_roll_q   <= set_roll_i;
      set_yaw_q    <= set_yaw_i;
      meas_pitch_q <= meas_pitch_i;
      meas_roll_q  <= meas_roll_i;
      meas_yaw_q   <= meas_yaw_i;
      rate_x_q     <= rate_x_i;
      rate_y_q     <= rate_y_i;
      rate_z_q     <= rate_z_i;
      throttle_q   <= throttle_i;
      armed_q      <= armed_i;
    end
    if (out_load) begin
      motor_a_q <= mix_a;
      motor_b_q <= mix_b;
      motor_c_q <= mix_c;
      motor_d_q <= mix_d;
    end
  end

  assign ctl.step  = step_q;
  assign ctl.armed = armed_q;

  assign gain_pitch.kp  = cfg_q[capm_pkg::REG_ANGLE_KP_TILT];
  assign gain_pitch.ki  = cfg_q[capm_pkg::REG_ANGLE_KI_TILT];
  assign gain_pitch.kd  = cfg_q[capm_pkg::REG_ANGLE_KD_TILT];
  assign gain_pitch.rkp = cfg_q[capm_pkg::REG_RATE_KP_PITCH];
  assign gain_pitch.rkd = cfg_q[capm_pkg::REG_RATE_KD_PITCH];

  assign gain_roll.kp  = cfg_q[capm_pkg::REG_ANGLE_KP_TILT];
  assign gain_roll.ki  = cfg_q[capm_pkg::REG_ANGLE_KI_TILT];
  assign gain_roll.kd  = cfg_q[capm_pkg::REG_ANGLE_KD_TILT];
  assign gain_roll.rkp = cfg_q[capm_pkg::REG_RATE_KP_ROLL];
  assign gain_roll.rkd = cfg_q[capm_pkg::REG_RATE_KD_ROLL];

  capm_lane u_lane_pitch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .gain_i     (gain_pitch),
    .set_i      (set_pitch_q),
    .meas_i     (meas_pitch_q),
    .gyro_i     (rate_y_q),
    .rate_out_o (pitch_out)
  );

  capm_lane u_lane_roll (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .gain_i     (gain_roll),
    .set_i      (set_roll_q),
    .meas_i     (meas_roll_q),
    .gyro_i     (rate_x_q),
    .rate_out_o (roll_out)
  );

  capm_merge u_merge (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .kp_yaw_i   (cfg_q[capm_pkg::REG_ANGLE_KP_YAW]),
    .set_yaw_i  (set_yaw_q),
    .meas_yaw_i (meas_yaw_q),
    .rate_z_i   (rate_z_q),
    .throttle_i (throttle_q),
    .pitch_i    (pitch_out),
    .roll_i     (roll_out),
    .motor_a_o  (mix_a),
    .motor_b_o  (mix_b),
    .motor_c_o  (mix_c),
    .motor_d_o  (mix_d)
  );

  assign out_valid_o = out_valid_q;
  assign motor_a_o   = motor_a_q;
  assign motor_b_o   = motor_b_q;
  assign motor_c_o   = motor_c_q;
  assign motor_d_o   = motor_d_q;

  `CAPM_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_accept, step_q == capm_pkg::S_ERR)
  `CAPM_ASSERT_NEXT(a_load_valid, clk_i, rst_ni, out_load, out_valid_o && !in_stall_o)
  `CAPM_ASSERT_NEXT(a_disarmed_zero, clk_i, rst_ni, out_load && !armed_q, motor_a_o == 16'sd0 && motor_b_o == 16'sd0 && motor_c_o == 16'sd0 && motor_d_o == 16'sd0)
  `CAPM_ASSERT_IMPL(a_busy_stalls, clk_i, rst_ni, step_q != capm_pkg::S_IDLE, in_stall_o)

endmodule
`default_nettype wire

>>> rtl/capm_lane.sv
// One tilt axis lane: outer angle PID followed by inner rate PD.
`default_nettype none
module capm_lane (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire capm_pkg::ctl_t      ctl_i,
  input  wire capm_pkg::lane_gain_t gain_i,
  input  wire logic signed [15:0]  set_i,
  input  wire logic signed [15:0]  meas_i,
  input  wire logic signed [15:0]  gyro_i,
  output logic signed [15:0]       rate_out_o
);

  // State
  logic signed [31:0] integ_q;
  logic signed [16:0] tprev_q;
  logic signed [17:0] rprev_q;

  // Stage registers
  logic signed [16:0] err_q;
  logic signed [31:0] s_q;
  logic signed [17:0] d_q;
  logic signed [33:0] p1_q;
  logic signed [48:0] p2_q;
  logic signed [34:0] p3_q;
  logic signed [16:0] ao_q;
  logic signed [17:0] rerr_q;
  logic signed [18:0] rd_q;
  logic signed [34:0] q1_q;
  logic signed [35:0] q2_q;
  logic signed [15:0] rate_q;

  logic signed [16:0] err_c;
  logic signed [33:0] s_sum;
  logic signed [31:0] s_c;
  logic signed [17:0] d_c;
  logic signed [47:0] asum_c;
  logic signed [17:0] rerr_c;
  logic signed [18:0] rd_c;
  logic signed [31:0] rsum_c;
  logic signed [16:0] kp_s, ki_s, kd_s, rkp_s, rkd_s;

  assign kp_s  = signed'({1'b0, gain_i.kp});
  assign ki_s  = signed'({1'b0, gain_i.ki});
  assign kd_s  = signed'({1'b0, gain_i.kd});
  assign rkp_s = signed'({1'b0, gain_i.rkp});
  assign rkd_s = signed'({1'b0, gain_i.rkd});

  assign err_c = 17'(set_i) - 17'(meas_i);
  assign s_sum = 34'(integ_q) + 34'(err_c);
  assign d_c   = 18'(err_c) - 18'(tprev_q);

  // Clamp above at the limit, saturate below at the most negative 32-bit value.
  always_comb begin
    if (s_sum > 34'(capm_pkg::INTEG_LIMIT)) begin
      s_c = 32'(capm_pkg::INTEG_LIMIT);
    end else if (s_sum[33] && !(s_sum[32] && s_sum[31])) begin
      s_c = {1'b1, 31'b0};
    end else begin
      s_c = s_sum[31:0];
    end
  end

  assign asum_c = 48'(p1_q >>> capm_pkg::GAIN_FRAC_BITS)
                + 48'(p2_q >>> capm_pkg::GAIN_FRAC_BITS)
                + 48'(p3_q >>> capm_pkg::GAIN_FRAC_BITS);

  assign rerr_c = 18'(gyro_i) - 18'(ao_q);
  assign rd_c   = 19'(rerr_c) - 19'(rprev_q);

  assign rsum_c = 32'(q1_q >>> capm_pkg::GAIN_FRAC_BITS)
                + 32'(q2_q >>> capm_pkg::GAIN_FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      tprev_q <= '0;
      rprev_q <= '0;
    end else begin
      if (ctl_i.armed && ctl_i.step == capm_pkg::S_ERR) begin
        integ_q <= s_c;
        tprev_q <= err_c;
      end
      if (ctl_i.armed && ctl_i.step == capm_pkg::S_RERR) begin
        rprev_q <= rerr_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step == capm_pkg::S_ERR) begin
      err_q <= err_c;
      s_q   <= s_c;
      d_q   <= d_c;
    end
    if (ctl_i.step == capm_pkg::S_AMUL) begin
      p1_q <= kp_s * err_q;
      p2_q <= ki_s * s_q;
      p3_q <= kd_s * d_q;
    end
    if (ctl_i.step == capm_pkg::S_ASUM) begin
      ao_q <= capm_pkg::sat17(asum_c);
    end
    if (ctl_i.step == capm_pkg::S_RERR) begin
      rerr_q <= rerr_c;
      rd_q   <= rd_c;
    end
    if (ctl_i.step == capm_pkg::S_RMUL) begin
      q1_q <= rkp_s * rerr_q;
      q2_q <= rkd_s * rd_q;
    end
    if (ctl_i.step == capm_pkg::S_RSUM) begin
      rate_q <= capm_pkg::sat16(rsum_c);
    end
  end

  assign rate_out_o = rate_q;

endmodule
`default_nettype wire

>>> rtl/capm_merge.sv
// Yaw path and X-frame mixer combining the lane outputs into four motors.
`default_nettype none
module capm_merge (
  input  wire logic               clk_i,
  input  wire capm_pkg::ctl_t     ctl_i,
  input  wire logic [15:0]        kp_yaw_i,
  input  wire logic signed [15:0] set_yaw_i,
  input  wire logic signed [15:0] meas_yaw_i,
  input  wire logic signed [15:0] rate_z_i,
  input  wire logic [14:0]        throttle_i,
  input  wire logic signed [15:0] pitch_i,
  input  wire logic signed [15:0] roll_i,
  output logic signed [15:0]      motor_a_o,
  output logic signed [15:0]      motor_b_o,
  output logic signed [15:0]      motor_c_o,
  output logic signed [15:0]      motor_d_o
);

  logic signed [33:0] yp_q;
  logic signed [16:0] ay_q;
  logic signed [15:0] y_q;

  logic signed [16:0] ey_c;
  logic signed [16:0] ky_s;
  logic signed [17:0] yd_c;
  logic signed [19:0] y3_c;
  logic signed [18:0] thr_s, p_s, r_s, y_s;
  logic signed [18:0] ma, mb, mc, md;

  assign ky_s = signed'({1'b0, kp_yaw_i});
  assign ey_c = 17'(set_yaw_i) - 17'(meas_yaw_i);
  assign yd_c = 18'(rate_z_i) - 18'(ay_q);
  assign y3_c = (20'(yd_c) <<< 1) + 20'(yd_c);

  always_ff @(posedge clk_i) begin
    if (ctl_i.step == capm_pkg::S_AMUL) begin
      yp_q <= ky_s * ey_c;
    end
    if (ctl_i.step == capm_pkg::S_ASUM) begin
      ay_q <= capm_pkg::sat17(48'(yp_q >>> capm_pkg::GAIN_FRAC_BITS));
    end
    if (ctl_i.step == capm_pkg::S_RERR) begin
      y_q <= capm_pkg::sat16(32'(y3_c));
    end
  end

  assign thr_s = signed'({4'b0, throttle_i});
  assign p_s   = 19'(pitch_i);
  assign r_s   = 19'(roll_i);
  assign y_s   = 19'(y_q);

  assign ma = thr_s - p_s + r_s - y_s;
  assign mb = thr_s - p_s - r_s + y_s;
  assign mc = thr_s + p_s - r_s - y_s;
  assign md = thr_s + p_s + r_s + y_s;

  // Force zero drive when disarmed.
  assign motor_a_o = ctl_i.armed ? capm_pkg::sat16(32'(ma)) : 16'sd0;
  assign motor_b_o = ctl_i.armed ? capm_pkg::sat16(32'(mb)) : 16'sd0;
  assign motor_c_o = ctl_i.armed ? capm_pkg::sat16(32'(mc)) : 16'sd0;
  assign motor_d_o = ctl_i.armed ? capm_pkg::sat16(32'(md)) : 16'sd0;

endmodule
`default_nettype wire

>>> verif/cascaded_attitude_pid_mixer_top_tb.sv
// Self-checking testbench for the cascaded attitude PID mixer top level.
module cascaded_attitude_pid_mixer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CYCLE_LIMIT = 2_000_000;
  localparam int     DRAIN_GAP   = 16;
  localparam int     AX_PITCH    = 0;
  localparam int     AX_ROLL     = 1;
  localparam longint YAW_RATE_KP = 3;
  localparam longint ANGLE_MIN   = -65536;
  localparam longint ANGLE_MAX   = 65535;
  localparam longint S16_MIN     = -32768;
  localparam longint S16_MAX     = 32767;
  localparam longint INTEG_FLOOR = -64'sd2147483648;
  localparam int     WIND_TICKS  = 24;

  typedef enum int {GAINS_RANDOM, GAINS_MAX, GAINS_ZERO, GAINS_NEAR_DEFAULT} gain_mode_e;

  typedef struct {
    logic signed [15:0] set_pitch, set_roll, set_yaw;
    logic signed [15:0] meas_pitch, meas_roll, meas_yaw;
    logic signed [15:0] rate_x, rate_y, rate_z;
    logic [14:0]        throttle;
    logic               armed;
  } tick_t;

  typedef struct {
    logic signed [15:0] a, b, c, d;
  } motors_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] set_pitch_i = '0, set_roll_i = '0, set_yaw_i = '0;
  logic signed [15:0] meas_pitch_i = '0, meas_roll_i = '0, meas_yaw_i = '0;
  logic signed [15:0] rate_x_i = '0, rate_y_i = '0, rate_z_i = '0;
  logic [14:0] throttle_i = '0;
  logic armed_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] motor_a_o, motor_b_o, motor_c_o, motor_d_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  cascaded_attitude_pid_mixer_top u_top (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: gains and loop memories, pitch then roll.
  logic [15:0] gain [capm_pkg::NUM_REGS];
  longint tilt_acc [2] = '{0, 0};
  longint tilt_err_q [2] = '{0, 0};
  longint rate_err_q [2] = '{0, 0};

  tick_t   tick_q [$];
  motors_t motor_q [$];
  tick_t   tick_on_bus;
  bit      in_fire = 1'b0;
  int      snd_idle_pct = 0;
  int      rcv_stall_pct = 0;
  int      hold_ask = 0;
  int      hold_left = 0;
  int      mismatches = 0;
  int      cycle_count = 0;

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint tilt_step(int k, longint err);
    longint acc, dlt, o;
    acc = tilt_acc[k] + err;
    if (acc > capm_pkg::INTEG_LIMIT) acc = capm_pkg::INTEG_LIMIT;
    if (acc < INTEG_FLOOR) acc = INTEG_FLOOR;
    dlt = err - tilt_err_q[k];
    tilt_acc[k] = acc;
    tilt_err_q[k] = err;
    o = ((longint'(gain[capm_pkg::REG_ANGLE_KP_TILT]) * err) >>> capm_pkg::GAIN_FRAC_BITS)
      + ((longint'(gain[capm_pkg::REG_ANGLE_KI_TILT]) * acc) >>> capm_pkg::GAIN_FRAC_BITS)
      + ((longint'(gain[capm_pkg::REG_ANGLE_KD_TILT]) * dlt) >>> capm_pkg::GAIN_FRAC_BITS);
    return clamp_range(o, ANGLE_MIN, ANGLE_MAX);
  endfunction

  function automatic longint rate_step(int k, longint gyro, longint cmd, longint kp, longint kd);
    longint err, dlt;
    err = gyro - cmd;
    dlt = err - rate_err_q[k];
    rate_err_q[k] = err;
    return clamp_range(((kp * err) >>> capm_pkg::GAIN_FRAC_BITS)
                       + ((kd * dlt) >>> capm_pkg::GAIN_FRAC_BITS),
                       S16_MIN, S16_MAX);
  endfunction

  function automatic motors_t predict_motors(tick_t t);
    motors_t m;
    longint ap, ar, ay, p, r, y, thr;
    m = '{default: '0};
    if (!t.armed) return m;  // disarmed: zero drive, loop memories hold
    ap = tilt_step(AX_PITCH, longint'(t.set_pitch) - longint'(t.meas_pitch));
    ar = tilt_step(AX_ROLL, longint'(t.set_roll) - longint'(t.meas_roll));
    ay = clamp_range((longint'(gain[capm_pkg::REG_ANGLE_KP_YAW])
                      * (longint'(t.set_yaw) - longint'(t.meas_yaw)))
                     >>> capm_pkg::GAIN_FRAC_BITS,
                     ANGLE_MIN, ANGLE_MAX);
    p = rate_step(AX_PITCH, longint'(t.rate_y), ap,
                  longint'(gain[capm_pkg::REG_RATE_KP_PITCH]),
                  longint'(gain[capm_pkg::REG_RATE_KD_PITCH]));
    r = rate_step(AX_ROLL, longint'(t.rate_x), ar,
                  longint'(gain[capm_pkg::REG_RATE_KP_ROLL]),
                  longint'(gain[capm_pkg::REG_RATE_KD_ROLL]));
    y = clamp_range(YAW_RATE_KP * (longint'(t.rate_z) - ay), S16_MIN, S16_MAX);
    thr = longint'(t.throttle);
    m.a = 16'(clamp_range(thr - p + r - y, S16_MIN, S16_MAX));
    m.b = 16'(clamp_range(thr - p - r + y, S16_MIN, S16_MAX));
    m.c = 16'(clamp_range(thr + p - r - y, S16_MIN, S16_MAX));
    m.d = 16'(clamp_range(thr + p + r + y, S16_MIN, S16_MAX));
    return m;
  endfunction

  function automatic tick_t make_tick(logic signed [15:0] sp, sr, sy, mp, mr, my, rx, ry, rz,
                                      logic [14:0] thr, logic arm);
    tick_t t;
    t.set_pitch = sp;  t.set_roll = sr;  t.set_yaw = sy;
    t.meas_pitch = mp; t.meas_roll = mr; t.meas_yaw = my;
    t.rate_x = rx;     t.rate_y = ry;    t.rate_z = rz;
    t.throttle = thr;  t.armed = arm;
    return t;
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3, 4: return 16'($urandom_range(0, 600)) - 16'd300;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tick_t rand_tick();
    logic [14:0] thr;
    case ($urandom_range(0, 7))
      0:       thr = '0;
      1:       thr = '1;
      default: thr = 15'($urandom_range(0, 32767));
    endcase
    return make_tick(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                     rand_word(), rand_word(), rand_word(), rand_word(), thr,
                     $urandom_range(0, 9) != 0);
  endfunction

  function automatic void check_field(string name, logic signed [15:0] want, got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Input side: predict on each accepted transaction. Output side: compare in order.
  always @(posedge clk_i) begin
    motors_t want;
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (in_fire) motor_q.push_back(predict_motors(tick_on_bus));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (motor_q.size() == 0) begin
        $error("motor result with nothing outstanding");
        mismatches++;
      end else begin
        want = motor_q.pop_front();
        check_field("motor_a", want.a, motor_a_o);
        check_field("motor_b", want.b, motor_b_o);
        check_field("motor_c", want.c, motor_c_o);
        check_field("motor_d", want.d, motor_d_o);
      end
    end
  end

  // Driver: hold the offered tick until accepted, then maybe idle, then offer the next.
  always @(negedge clk_i) begin
    logic vld;
    vld = in_valid_i;
    if (in_fire) vld = 1'b0;
    if (rst_ni && !vld && tick_q.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
      tick_on_bus = tick_q.pop_front();
      set_pitch_i  <= tick_on_bus.set_pitch;
      set_roll_i   <= tick_on_bus.set_roll;
      set_yaw_i    <= tick_on_bus.set_yaw;
      meas_pitch_i <= tick_on_bus.meas_pitch;
      meas_roll_i  <= tick_on_bus.meas_roll;
      meas_yaw_i   <= tick_on_bus.meas_yaw;
      rate_x_i     <= tick_on_bus.rate_x;
      rate_y_i     <= tick_on_bus.rate_y;
      rate_z_i     <= tick_on_bus.rate_z;
      throttle_i   <= tick_on_bus.throttle;
      armed_i      <= tick_on_bus.armed;
      vld = 1'b1;
    end
    in_valid_i <= vld;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    logic stall_n;
    if (hold_ask > 0) begin
      hold_left = hold_ask;
      hold_ask = 0;
    end
    if (!rst_ni) begin
      stall_n = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      stall_n = 1'b1;
    end else begin
      stall_n = $urandom_range(0, 99) < rcv_stall_pct;
    end
    out_stall_i <= stall_n;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** cascaded_attitude_pid_mixer_top: FAILED **");
      $finish;
    end
  end

  task automatic drain();
    while (tick_q.size() > 0 || in_valid_i || motor_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic write_gain(input capm_pkg::reg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    gain[idx] = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_gains(input gain_mode_e mode);
    logic [15:0] val;
    for (int i = 0; i < capm_pkg::NUM_REGS; i++) begin
      case (mode)
        GAINS_MAX:          val = 16'hffff;
        GAINS_ZERO:         val = 16'h0000;
        GAINS_NEAR_DEFAULT: val = 16'($urandom_range(0, 2048));
        default:            val = 16'($urandom);
      endcase
      write_gain(capm_pkg::reg_idx_e'(i), val);
    end
  endtask

  task automatic push_random(input int count);
    repeat (count) tick_q.push_back(rand_tick());
  endtask

  initial begin
    foreach (gain[i]) gain[i] = capm_pkg::CFG_RESET[i];
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed ticks at reset gains.
    tick_q.push_back(make_tick('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1,
                               '1 >> 1, '1 >> 1, '1 >> 1, '1, 1'b0));
    tick_q.push_back(make_tick(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                               16'h8000, 16'h8000, 16'h8000, '0, 1'b0));
    tick_q.push_back(make_tick('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
    tick_q.push_back(make_tick('0, '0, '0, '0, '0, '0, '0, '0, '0, '1, 1'b1));
    // Large positive error: integrator pins at its upper clamp.
    repeat (3)
      tick_q.push_back(make_tick(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
                                 '0, '0, '0, 15'd16384, 1'b1));
    tick_q.push_back(make_tick(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                               '0, '0, '0, 15'd16384, 1'b1));
    tick_q.push_back(make_tick('0, '0, '0, '0, '0, '0, 16'h7fff, 16'h7fff, 16'h7fff, '1, 1'b1));
    tick_q.push_back(make_tick('0, '0, '0, '0, '0, '0, 16'h8000, 16'h8000, 16'h8000, '0, 1'b1));
    // Disarmed in between: state must hold across it.
    tick_q.push_back(make_tick(16'h1234, 16'h8000, 16'h7fff, 16'h5555, 16'haaaa, 16'h0001,
                               16'hffff, 16'h8000, 16'h7fff, 15'h2aaa, 1'b0));
    tick_q.push_back(make_tick(16'd100, -16'sd50, 16'd10, 16'd90, -16'sd40, 16'd0,
                               16'd5, -16'sd5, 16'd1, 15'd8000, 1'b1));
    tick_q.push_back(make_tick(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                               16'h5555, 16'haaaa, 16'h5555, 15'h5555, 1'b1));
    tick_q.push_back(make_tick(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                               16'haaaa, 16'h5555, 16'haaaa, 15'h2aaa, 1'b1));
    tick_q.push_back(make_tick('0, '0, 16'h7fff, '0, '0, 16'h8000, '0, '0, 16'h8000, '1, 1'b1));
    tick_q.push_back(make_tick('0, '0, 16'h8000, '0, '0, 16'h7fff, '0, '0, 16'h7fff, '0, 1'b1));
    tick_q.push_back(make_tick(-16'sd1, -16'sd1, -16'sd1, 16'd1, 16'd1, 16'd1,
                               -16'sd1, -16'sd1, -16'sd1, 15'd1, 1'b1));
    drain();

    load_gains(GAINS_RANDOM);
    snd_idle_pct = 65;
    rcv_stall_pct = 0;
    push_random(290);
    drain();

    // Full-scale gains; long receiver hold-off while ticks keep coming.
    load_gains(GAINS_MAX);
    snd_idle_pct = 0;
    rcv_stall_pct = 65;
    push_random(290);
    while (motor_q.size() == 0) @(posedge clk_i);
    hold_ask = 300;
    drain();

    load_gains(GAINS_ZERO);
    snd_idle_pct = 38;
    rcv_stall_pct = 38;
    push_random(300);
    drain();

    // Sender pauses midway until every result is back.
    load_gains(GAINS_NEAR_DEFAULT);
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    push_random(135);
    drain();
    push_random(135);
    drain();

    // Sustained negative error drives the tilt integrators well below zero.
    load_gains(GAINS_NEAR_DEFAULT);
    repeat (WIND_TICKS)
      tick_q.push_back(make_tick(16'h8000, 16'h8000, rand_word(), 16'h7fff, 16'h7fff,
                                 rand_word(), rand_word(), rand_word(), rand_word(),
                                 15'($urandom_range(0, 32767)), 1'b1));
    push_random(20);
    drain();

    if (mismatches == 0) begin
      $display("** cascaded_attitude_pid_mixer_top: PASSED **");
    end else begin
      $display("** cascaded_attitude_pid_mixer_top: FAILED **");
    end
    $finish;
  end

endmodule
